// File: design/s256_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte-stream hasher.
// No dependencies; every other design file except the port checker imports this package.

package s256_pkg;

  // Number of 32-bit words in one 512-bit message block.
  localparam int unsigned BlockWords = 16;
  // Depth of the word queue between the front and the back.
  localparam int unsigned QDepth = 16;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  // Word positions inside a block that the padding logic cares about.
  localparam logic [3:0] PosLastZero = 4'd13;
  localparam logic [3:0] PosLast = 4'd15;
  // Padding marker byte that follows the last message byte.
  localparam logic [7:0] PadByte = 8'h80;

  // SHA-256 round constants.
  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // SHA-256 initial hash values.
  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // One queue entry: a big-endian message word and the end-of-message mark.
  typedef struct packed {
    logic        msg_end;
    logic [31:0] word;
  } q_entry_t;

  typedef enum logic [2:0] {
    FrIdle,
    FrPadFirst,
    FrPadZero,
    FrLenHi,
    FrLenLo
  } front_state_e;

  typedef enum logic [1:0] {
    BkRound,
    BkAdd,
    BkOut
  } back_state_e;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned s);
    return (x >> s) | (x << (32 - s));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// File: design/s256_front.sv
// Front end of the SHA-256 hasher: takes byte items, packs them into words,
// appends padding and the bit length. Depends on s256_pkg.

module s256_front import s256_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     mode_i,
  input  logic [7:0] data_byte_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output q_entry_t q_entry_o
);

  front_state_e state_q, state_d;
  logic [23:0] acc_q, acc_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [3:0]  word_pos_q, word_pos_d;
  logic [63:0] msg_bits_q, msg_bits_d;
  logic        accept;
  logic [31:0] pad_word;

  // Items enter only between messages' padding sequences and with queue room.
  assign in_ready_o = (state_q == FrIdle) && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Word holding the buffered bytes followed by the padding marker.
  always_comb begin
    case (byte_idx_q)
      2'd0:    pad_word = {PadByte, 24'h0};
      2'd1:    pad_word = {acc_q[7:0], PadByte, 16'h0};
      2'd2:    pad_word = {acc_q[15:0], PadByte, 8'h0};
      default: pad_word = {acc_q[23:0], PadByte};
    endcase
  end

  // Next state, packing and padding word generation.
  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    byte_idx_d = byte_idx_q;
    word_pos_d = word_pos_q;
    msg_bits_d = msg_bits_q;
    q_push_o   = 1'b0;
    q_entry_o  = '{msg_end: 1'b0, word: 32'h0};
    case (state_q)
      FrIdle: begin
        if (accept) begin
          if (!mode_i) begin
            acc_d      = {acc_q[15:0], data_byte_i};
            byte_idx_d = byte_idx_q + 2'd1;
            msg_bits_d = msg_bits_q + 64'd8;
            if (byte_idx_q == 2'd3) begin
              q_push_o       = 1'b1;
              q_entry_o.word = {acc_q, data_byte_i};
              word_pos_d     = word_pos_q + 4'd1;
            end
          end else begin
            state_d = FrPadFirst;
          end
        end
      end
      FrPadFirst: begin
        if (!q_full_i) begin
          q_push_o       = 1'b1;
          q_entry_o.word = pad_word;
          byte_idx_d     = 2'd0;
          word_pos_d     = word_pos_q + 4'd1;
          state_d        = (word_pos_q == PosLastZero) ? FrLenHi : FrPadZero;
        end
      end
      FrPadZero: begin
        if (!q_full_i) begin
          q_push_o   = 1'b1;
          word_pos_d = word_pos_q + 4'd1;
          if (word_pos_q == PosLastZero) begin
            state_d = FrLenHi;
          end
        end
      end
      FrLenHi: begin
        if (!q_full_i) begin
          q_push_o       = 1'b1;
          q_entry_o.word = msg_bits_q[63:32];
          word_pos_d     = word_pos_q + 4'd1;
          state_d        = FrLenLo;
        end
      end
      FrLenLo: begin
        if (!q_full_i) begin
          q_push_o          = 1'b1;
          q_entry_o.word    = msg_bits_q[31:0];
          q_entry_o.msg_end = 1'b1;
          word_pos_d        = word_pos_q + 4'd1;
          msg_bits_d        = 64'h0;
          state_d           = FrIdle;
        end
      end
      default: begin
        state_d = FrIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FrIdle;
      byte_idx_q <= 2'd0;
      word_pos_q <= 4'd0;
      msg_bits_q <= 64'h0;
    end else begin
      state_q    <= state_d;
      byte_idx_q <= byte_idx_d;
      word_pos_q <= word_pos_d;
      msg_bits_q <= msg_bits_d;
    end
  end

  // Partial word of buffered bytes.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

// File: design/s256_queue.sv
// Word queue between the front and the back of the SHA-256 hasher.
// Depends on s256_pkg for the entry type and depth.

module s256_queue import s256_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t head_o
);

  q_entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]     count_q;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// File: design/s256_back.sv
// Back end of the SHA-256 hasher: one compression round per cycle while the queue
// supplies words, chaining hash update and digest output register. Depends on s256_pkg.

module s256_back import s256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  q_entry_t    q_head_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  back_state_e state_q, state_d;
  logic [5:0]  t_q, t_d;
  logic [31:0] r_q [8];
  logic [31:0] r_d [8];
  logic [31:0] h_q [8];
  logic [31:0] h_d [8];
  logic [31:0] w_q [BlockWords];
  logic        fin_q, fin_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic        out_valid_q, out_valid_d;
  logic        out_load;
  logic [31:0] out_word_q;
  logic [2:0]  out_index_q;
  logic        out_last_q;

  logic        need_word;
  logic        step;
  logic [31:0] sched;
  logic [31:0] wt;
  logic [31:0] t1, t2;
  logic [31:0] ch, maj;

  // Rounds 0 to 15 take their word from the queue, later ones from the schedule.
  assign need_word = (t_q[5:4] == 2'b00);
  assign step      = (state_q == BkRound) && (!need_word || q_valid_i);
  assign q_pop_o   = step && need_word;
  assign sched     = small_sig1(w_q[14]) + w_q[9] + small_sig0(w_q[1]) + w_q[0];
  assign wt        = need_word ? q_head_i.word : sched;

  // Round function.
  assign ch  = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
  assign maj = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
  assign t1  = r_q[7] + big_sig1(r_q[4]) + ch + RoundK[t_q] + wt;
  assign t2  = big_sig0(r_q[0]) + maj;

  // Digest words leave through a register that frees when taken.
  assign out_load      = (state_q == BkOut) && (!out_valid_q || out_ready_i);
  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign word_index_o  = out_index_q;
  assign last_word_o   = out_last_q;

  // Next state of the round engine and chaining hash.
  always_comb begin
    state_d   = state_q;
    t_d       = t_q;
    r_d       = r_q;
    h_d       = h_q;
    fin_d     = fin_q;
    out_idx_d = out_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      BkRound: begin
        if (step) begin
          r_d[7] = r_q[6];
          r_d[6] = r_q[5];
          r_d[5] = r_q[4];
          r_d[4] = r_q[3] + t1;
          r_d[3] = r_q[2];
          r_d[2] = r_q[1];
          r_d[1] = r_q[0];
          r_d[0] = t1 + t2;
          t_d    = t_q + 6'd1;
          if (t_q == 6'd15) begin
            fin_d = q_head_i.msg_end;
          end
          if (t_q == 6'd63) begin
            state_d = BkAdd;
          end
        end
      end
      BkAdd: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + r_q[i];
          r_d[i] = h_q[i] + r_q[i];
        end
        out_idx_d = 3'd0;
        state_d   = fin_q ? BkOut : BkRound;
      end
      BkOut: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_idx_d   = out_idx_q + 3'd1;
          if (out_idx_q == 3'd7) begin
            h_d     = InitHash;
            r_d     = InitHash;
            fin_d   = 1'b0;
            state_d = BkRound;
          end
        end
      end
      default: begin
        state_d = BkRound;
      end
    endcase
  end

  // Control state, working variables and chaining hash.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkRound;
      t_q         <= 6'd0;
      r_q         <= InitHash;
      h_q         <= InitHash;
      fin_q       <= 1'b0;
      out_idx_q   <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      t_q         <= t_d;
      r_q         <= r_d;
      h_q         <= h_d;
      fin_q       <= fin_d;
      out_idx_q   <= out_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Message schedule window, newest word at the top.
  always_ff @(posedge clk_i) begin
    if (step) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[BlockWords-1] <= wt;
    end
  end

  // Digest output payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q  <= h_q[out_idx_q];
      out_index_q <= out_idx_q;
      out_last_q  <= (out_idx_q == 3'd7);
    end
  end

endmodule

// File: design/sha256_byte_stream_hasher_core.sv
// SHA-256 hasher: one byte item per cycle while the word queue has room; a finish item
// then blocks input while the padding words are queued.
// Each 64-byte block passes through the single round unit as 64 rounds and one hash update.
// Digest: eight items, one per cycle while the receiver takes them, the first once the
// round unit has finished the rounds and hash update of the message's final block.
// Reset (asynchronous, active low) loads the initial hash, clears control state and empties the queue.

module sha256_byte_stream_hasher_core import s256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  logic     q_full, q_push, q_pop, q_valid;
  q_entry_t q_push_entry, q_head;

  // Byte packing and padding.
  s256_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_push_entry)
  );

  // Word queue between the two halves.
  s256_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  // Compression rounds and digest output.
  s256_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

endmodule

// File: design/s256_checker.sv
// Port-level checks for the SHA-256 hasher top level, bound to it below.
// Depends only on the top level's ports.

module s256_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        mode_i,
  input logic [7:0]  data_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  // A stalled digest item stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("digest item withdrawn before it was taken");

  // A stalled digest item keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      ($stable(digest_word_o) && $stable(word_index_o) && $stable(last_word_o)))
    else $error("digest payload changed while stalled");

  // The final mark sits on the eighth word and nowhere else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last-word mark does not match the word index");

  // Digest words taken back to back come out in index order, wrapping from word seven to word zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=>
      (!out_valid_o || (word_index_o == $past(word_index_o) + 3'd1)))
    else $error("digest word out of sequence");

endmodule

bind sha256_byte_stream_hasher_core s256_checker u_s256_checker (.*);

// File: test/sha256_digest_checker.sv
// Digest checker for the SHA-256 byte-stream hasher: watches both channels, predicts
// the digest words of every finished message and compares them with what the core emits.
// Self-contained predictor; instantiated by sha256_byte_stream_hasher_core_tb.

module sha256_digest_checker #(
  parameter logic ModeFinish = 1'b1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          words_checked_o
);

  localparam int BlockLen = 64;
  localparam int LenPos = 56;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [2:0] LastPos = 3'd7;

  localparam logic [31:0] RoundTbl [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IvWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // One predicted digest word as the output channel should carry it.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  pos;
    logic        last;
  } digest_word_t;

  digest_word_t digest_q [$];
  digest_word_t head;

  // Predictor state: chaining hash, block buffer, bytes held and message length in bits.
  logic [31:0] hash_r [8];
  logic [7:0]  msg_buf [BlockLen];
  int          fill;
  logic [63:0] bit_len;

  int fails = 0;
  int checked = 0;

  function automatic logic [31:0] rot_right(input logic [31:0] v, input int s);
    logic [63:0] dbl;
    dbl = {v, v} >> s;
    return dbl[31:0];
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) begin
      hash_r[i] = IvWords[i];
    end
    fill = 0;
    bit_len = '0;
  endfunction

  // Runs the 64 rounds over the buffer and adds the result into the chaining hash.
  function automatic void fold_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] s0;
    logic [31:0] s1;
    for (int t = 0; t < 16; t++) begin
      w[t] = {msg_buf[4*t], msg_buf[4*t+1], msg_buf[4*t+2], msg_buf[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = rot_right(w[t-15], 7) ^ rot_right(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rot_right(w[t-2], 17) ^ rot_right(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) begin
      v[i] = hash_r[i];
    end
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundTbl[t] + w[t];
      t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) begin
        v[i] = v[i-1];
      end
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) begin
      hash_r[i] = hash_r[i] + v[i];
    end
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    msg_buf[fill] = b;
    bit_len = bit_len + 64'd8;
    fill++;
    if (fill == BlockLen) begin
      fold_block();
      fill = 0;
    end
  endfunction

  // Pads the message, appends its length, and queues the eight digest words.
  function automatic void finish_message();
    int p;
    digest_word_t dw;
    p = fill;
    msg_buf[p] = PadMark;
    p++;
    if (p > LenPos) begin
      while (p < BlockLen) begin
        msg_buf[p] = 8'h00;
        p++;
      end
      fold_block();
      p = 0;
    end
    while (p < LenPos) begin
      msg_buf[p] = 8'h00;
      p++;
    end
    for (int i = 0; i < 8; i++) begin
      msg_buf[LenPos + i] = bit_len[63 - 8*i -: 8];
    end
    fold_block();
    for (int i = 0; i < 8; i++) begin
      dw.word = hash_r[i];
      dw.pos = 3'(i);
      dw.last = (3'(i) == LastPos);
      digest_q.push_back(dw);
    end
    restart_message();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: digest check failed on %s: got %0h, expected %0h",
             $time, what, got, want);
    fails++;
  endtask

  // Compare accepted output items first, then fold in the accepted input item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_message();
      digest_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected word", digest_word_i, '0);
        end else begin
          head = digest_q.pop_front();
          if (digest_word_i !== head.word) begin
            report_mismatch("digest_word", digest_word_i, head.word);
          end
          if (word_index_i !== head.pos) begin
            report_mismatch("word_index", {29'd0, word_index_i}, {29'd0, head.pos});
          end
          if (last_word_i !== head.last) begin
            report_mismatch("last_word", {31'd0, last_word_i}, {31'd0, head.last});
          end
        end
        checked++;
      end
      if (in_valid_i && in_ready_i) begin
        if (mode_i == ModeFinish) begin
          finish_message();
        end else begin
          absorb_byte(data_byte_i);
        end
      end
    end
    fail_count_o <= fails;
    pending_o <= digest_q.size();
    words_checked_o <= checked;
  end

endmodule

// File: test/sha256_byte_stream_hasher_core_tb.sv
// Top of the SHA-256 hasher regression: clock, reset, byte-stream stimulus, output
// back-pressure and the verdict. Needs the core, s256_pkg and sha256_digest_checker.

module sha256_byte_stream_hasher_core_tb;

  localparam logic ModeAbsorb = 1'b0;
  localparam logic ModeFinish = 1'b1;
  localparam int TotalItems = 130;
  localparam int HoldCycles = 400;
  localparam int QuietLimit = 3000;
  localparam int DrainCycles = 100;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        mode_i = ModeAbsorb;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  int fail_count;
  int pending;
  int words_checked;

  int items_sent = 0;
  int messages_sent = 0;
  int holds_done = 0;
  int hold_cycles = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  sha256_byte_stream_hasher_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

  sha256_digest_checker #(
    .ModeFinish (ModeFinish)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .mode_i          (mode_i),
    .data_byte_i     (data_byte_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .digest_word_i   (digest_word_o),
    .word_index_i    (word_index_o),
    .last_word_i     (last_word_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Idle gap length: mostly none or short, now and then long, none in calm stretches.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Offers one item after an optional gap and waits until it is accepted.
  task automatic push_item(input logic m, input logic [7:0] b);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Random message body of the given length, then a finish item with a junk byte.
  task automatic push_message(input int len);
    for (int i = 0; i < len; i++) begin
      push_item(ModeAbsorb, 8'($urandom_range(0, 255)));
    end
    push_item(ModeFinish, 8'($urandom_range(0, 255)));
    messages_sent++;
  endtask

  // Stops offering items until every predicted digest word has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Output back-pressure, with an occasional long hold-off on request.
  initial begin : rx_side
    int stall;
    int run;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        rx_calm = !rx_calm;
      end
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
        holds_done++;
      end else begin
        stall = pick_gap(rx_calm);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      run = $urandom_range(1, 12);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
    end
  end

  // Ends the run if no item moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no item moved for %0d cycles, %0d words pending", QuietLimit, pending);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int len;
    int r;
    bit paused;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, "abc", all-zero and all-one bytes, back-to-back finishes.
    push_message(0);
    push_item(ModeAbsorb, 8'h61);
    push_item(ModeAbsorb, 8'h62);
    push_item(ModeAbsorb, 8'h63);
    push_item(ModeFinish, 8'h00);
    push_item(ModeAbsorb, 8'h00);
    push_item(ModeAbsorb, 8'hff);
    push_item(ModeFinish, 8'hff);
    push_item(ModeFinish, 8'ha5);
    push_item(ModeFinish, 8'h5a);
    messages_sent += 4;

    // Long receiver hold-off while the sender keeps offering items. The 63-byte
    // message spills its padding into an extra block and fills the word queue.
    tx_calm = 1'b1;
    hold_cycles = HoldCycles;
    push_message(2);
    push_message(63);
    for (int i = 0; i < 3; i++) begin
      push_message($urandom_range(1, 8));
    end
    wait_drained();

    // Random messages, mostly short, a few around one block, up to the item target.
    paused = 1'b0;
    while (items_sent < TotalItems) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r < 7) begin
        len = $urandom_range(0, 12);
      end else if (r < 9) begin
        len = $urandom_range(13, 30);
      end else begin
        len = $urandom_range(50, 70);
      end
      if (len > TotalItems - items_sent - 1) begin
        len = TotalItems - items_sent - 1;
      end
      push_message(len);
      if (!paused && items_sent > TotalItems / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Hashed %0d messages from %0d items, %0d digest words compared, %0d hold-offs.",
             messages_sent, items_sent, words_checked, holds_done);
    $display("Covered empty and short messages, padding spill and stalls on a full queue.");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
